### design/qpet_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature and PWM encoder tracker package
// Widths, reset values, request codes, register indexes and sequencer states
// shared by the tracker.
// ----------------------------------------------------------------------------
package qpet_pkg;

	// Word and digit geometry of the serial datapath.
	localparam int WORD_BITS    = 32;
	localparam int DIGIT_BITS   = 8;
	localparam int DIGIT_SHIFT  = $clog2(DIGIT_BITS);
	localparam int NUM_DIGITS   = WORD_BITS / DIGIT_BITS;
	localparam int DIG_IDX_BITS = $clog2(NUM_DIGITS);
	localparam int DSEL_BITS    = DIG_IDX_BITS + DIGIT_SHIFT;

	// Quadrature counter sample geometry.
	localparam int CNT_BITS     = 16;
	localparam int CNT_DIGITS   = CNT_BITS / DIGIT_BITS;
	localparam int CNT_IDX_BITS = $clog2(CNT_DIGITS);
	localparam int CSEL_BITS    = CNT_IDX_BITS + DIGIT_SHIFT;

	// PWM age and timeout.
	localparam int AGE_BITS     = 11;
	localparam int TIMEOUT_BITS = 10;
	localparam int MS_BITS      = 8;

	// Angle divider.
	localparam int QUOT_BITS    = 16;
	localparam int DIV_CNT_BITS = $clog2(QUOT_BITS);
	localparam int ANGLE_OFFSET = 16;

	// Configuration port.
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 4;
	localparam int REG_IDX_BITS  = 2;

	// Reset values.
	localparam logic [WORD_BITS-1:0]    TIMER_LOAD_RESET = 32'd3999999;
	localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET    = 10'd100;
	localparam logic [AGE_BITS-1:0]     AGE_RESET        = 11'd101;

	// Request codes.
	typedef enum logic [2:0] {
		REQ_TICK     = 3'd0,
		REQ_RISE     = 3'd1,
		REQ_FALL     = 3'd2,
		REQ_ZEDGE    = 3'd3,
		REQ_SET_ZERO = 3'd4
	} req_type_t;

	// Register indexes.
	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_TIMER_LOAD = 2'd0,
		REG_TIMEOUT    = 2'd1,
		REG_INVERT     = 2'd2
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_SPAN,
		ST_WRAP,
		ST_DIV_LOAD,
		ST_DIV,
		ST_DONE
	} seq_state_t;

endpackage

### design/quadrature_and_pwm_encoder_tracker_unit.sv
// ----------------------------------------------------------------------------
// Quadrature and PWM encoder tracker
// Extends a sampled quadrature counter into a wrapping position, counts index
// turns and measures a PWM duty cycle into an absolute angle. Arithmetic runs
// one 8-bit digit per cycle; the angle comes from a one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
// Paths from accept to result valid: a tick or Z edge runs the add digits; a
// PWM capture runs the span and wrap digits and, when the reading is in range,
// the 16-step divider; set zero, unused codes and early captures go straight to
// the result. The digit sequencer works on one item at a time, so the next item
// is taken the cycle after the result register loads. Reset (arst_n low) restores
// register defaults, sets age_q to AGE_RESET and clears the other tracking state.
module quadrature_and_pwm_encoder_tracker_unit
	import qpet_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,

	// Input item channel.
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [2:0]                req_type,
	input  logic [CNT_BITS-1:0]       qei_count,
	input  logic                      qei_down,
	input  logic [WORD_BITS-1:0]      capture_value,
	input  logic [MS_BITS-1:0]        tick_ms,

	// Result channel.
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [WORD_BITS-1:0] position,
	output logic signed [WORD_BITS-1:0] z_turns,
	output logic signed [WORD_BITS-1:0] position_at_z,
	output logic                      angle_valid,
	output logic [QUOT_BITS-1:0]      pwm_angle,

	// Configuration port.
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_BITS-1:0]  paddr,
	input  logic [APB_DATA_BITS-1:0]  pwdata,
	output logic [APB_DATA_BITS-1:0]  prdata,
	output logic                      pready
);

	// Configuration registers.
	logic [WORD_BITS-1:0]    timer_load_q;
	logic [TIMEOUT_BITS-1:0] timeout_q;
	logic                    invert_q;

	// Tracking state.
	logic [WORD_BITS-1:0] accum_q;
	logic [WORD_BITS-1:0] zoff_q;
	logic [WORD_BITS-1:0] pos_q;
	logic [CNT_BITS-1:0]  last_q;
	logic [WORD_BITS-1:0] turn_q;
	logic [WORD_BITS-1:0] zpos_q;
	logic [WORD_BITS-1:0] last_rise_q;
	logic [WORD_BITS-1:0] period_q;
	logic [WORD_BITS-1:0] high_q;
	logic [AGE_BITS-1:0]  age_q;
	logic                 seen_rise_q;
	logic                 pwm_ok_q;
	logic                 in_range_q;
	logic [QUOT_BITS-1:0] angle_q;

	// Item held while it is worked on.
	req_type_t            req_q;
	logic [CNT_BITS-1:0]  sample_q;
	logic                 down_q;
	logic [WORD_BITS-1:0] cap_q;

	// Sequencer, digit counter, carries and scratch.
	seq_state_t              state_q, state_d;
	logic [DIG_IDX_BITS-1:0] dig_q;
	logic                    dbor_q;
	logic                    acy_q;
	logic                    pcy_q;
	logic                    tcy_q;
	logic                    scy_q;
	logic                    wcy_q;
	logic                    kcy_q;
	logic                    sign_q;
	logic                    wrap_q;
	logic                    nz_q;
	logic [WORD_BITS-1:0]    tmp_q;
	logic [WORD_BITS-1:0]    rem_q;
	logic [QUOT_BITS-1:0]    quot_q;
	logic [DIV_CNT_BITS-1:0] div_cnt_q;

	// Result register.
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_pos_q;
	logic [WORD_BITS-1:0] out_turn_q;
	logic [WORD_BITS-1:0] out_zpos_q;
	logic                 out_avalid_q;
	logic [QUOT_BITS-1:0] out_angle_q;

	// Handshake terms.
	logic in_xfer;
	logic out_load;
	logic cfg_write;
	logic last_dig;
	logic last_div;
	reg_idx_t reg_sel;

	// Digit selection.
	logic [DSEL_BITS-1:0]  dsel;
	logic [CSEL_BITS-1:0]  csel;
	logic                  cnt_lo;

	// Count delta, position and turn chains.
	logic [DIGIT_BITS-1:0] s_dig, l_dig, d_dig, t_add;
	logic [DIGIT_BITS:0]   d_sum, a_sum, p_sum, t_sum;
	logic                  turn_neg;

	// Capture span and compare chains.
	logic [DIGIT_BITS:0]   x_sum, r_sum, k_sum;
	logic [DIGIT_BITS-1:0] per_e, hi_e;
	logic                  nz_n;
	logic                  is_rise;

	// Divider step.
	logic [WORD_BITS:0]    r2;
	logic [WORD_BITS+1:0]  dv;
	logic                  ge;
	logic [QUOT_BITS-1:0]  quot_n;
	logic [QUOT_BITS-1:0]  angle_n;

	// Age update on a tick.
	logic [AGE_BITS-1:0]   age_n;
	logic                  age_live;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_sel   = reg_idx_t'(paddr[REG_IDX_BITS+1:2]);
	assign last_dig  = (dig_q == DIG_IDX_BITS'(NUM_DIGITS - 1));
	assign last_div  = (div_cnt_q == DIV_CNT_BITS'(QUOT_BITS - 1));
	assign is_rise   = (req_q == REQ_RISE);
	assign turn_neg  = down_q ^ invert_q;

	// Configuration read mux.
	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_TIMER_LOAD: prdata = timer_load_q;
			REG_TIMEOUT:    prdata = APB_DATA_BITS'(timeout_q);
			REG_INVERT:     prdata = APB_DATA_BITS'(invert_q);
			default:        prdata = '0;
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_load_q <= TIMER_LOAD_RESET;
			timeout_q    <= TIMEOUT_RESET;
			invert_q     <= 1'b0;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_TIMER_LOAD: timer_load_q <= pwdata[WORD_BITS-1:0];
				REG_TIMEOUT:    timeout_q    <= pwdata[TIMEOUT_BITS-1:0];
				REG_INVERT:     invert_q     <= pwdata[0];
				default:        ;
			endcase
		end
	end

	// Digit datapath: every chain works on the digit picked by dig_q.
	always_comb begin
		dsel   = {dig_q, {DIGIT_SHIFT{1'b0}}};
		csel   = {dig_q[CNT_IDX_BITS-1:0], {DIGIT_SHIFT{1'b0}}};
		cnt_lo = (dig_q < DIG_IDX_BITS'(CNT_DIGITS));

		// Counter difference; digits above the sample carry its sign.
		s_dig = sample_q[csel +: DIGIT_BITS];
		l_dig = last_q[csel +: DIGIT_BITS];
		d_sum = {1'b0, s_dig} - {1'b0, l_dig} - {{DIGIT_BITS{1'b0}}, dbor_q};
		d_dig = cnt_lo ? d_sum[DIGIT_BITS-1:0] : {DIGIT_BITS{sign_q}};

		// Accumulated count plus or minus the delta, then minus the zero offset.
		a_sum = {1'b0, accum_q[dsel +: DIGIT_BITS]}
			+ {1'b0, (invert_q ? ~d_dig : d_dig)}
			+ {{DIGIT_BITS{1'b0}}, acy_q};
		p_sum = {1'b0, a_sum[DIGIT_BITS-1:0]}
			+ {1'b0, ~zoff_q[dsel +: DIGIT_BITS]}
			+ {{DIGIT_BITS{1'b0}}, pcy_q};

		// Turn count step of plus or minus one.
		if (turn_neg) begin
			t_add = {DIGIT_BITS{1'b1}};
		end else begin
			t_add = (dig_q == '0) ? DIGIT_BITS'(1) : '0;
		end
		t_sum = {1'b0, turn_q[dsel +: DIGIT_BITS]} + {1'b0, t_add}
			+ {{DIGIT_BITS{1'b0}}, tcy_q};

		// Older capture minus newer capture.
		x_sum = {1'b0, last_rise_q[dsel +: DIGIT_BITS]}
			+ {1'b0, ~cap_q[dsel +: DIGIT_BITS]}
			+ {{DIGIT_BITS{1'b0}}, scy_q};

		// Add the wrap span when the timer wrapped between the captures.
		r_sum = {1'b0, tmp_q[dsel +: DIGIT_BITS]}
			+ {1'b0, (wrap_q ? timer_load_q[dsel +: DIGIT_BITS] : {DIGIT_BITS{1'b0}})}
			+ {{DIGIT_BITS{1'b0}}, wcy_q};

		// Period above high time, with the digit being written taken as new.
		per_e = is_rise ? r_sum[DIGIT_BITS-1:0] : period_q[dsel +: DIGIT_BITS];
		hi_e  = is_rise ? high_q[dsel +: DIGIT_BITS] : r_sum[DIGIT_BITS-1:0];
		k_sum = {1'b0, per_e} + {1'b0, ~hi_e} + {{DIGIT_BITS{1'b0}}, kcy_q};
		nz_n  = nz_q || (hi_e != '0);
	end

	// Restoring divider step and angle offset.
	always_comb begin
		r2      = {rem_q, 1'b0};
		dv      = {1'b0, r2} - {2'b00, period_q};
		ge      = !dv[WORD_BITS+1];
		quot_n  = {quot_q[QUOT_BITS-2:0], ge};
		angle_n = (quot_n > QUOT_BITS'(ANGLE_OFFSET)) ?
			(quot_n - QUOT_BITS'(ANGLE_OFFSET)) : '0;
	end

	// PWM age advances on a tick until it passes the timeout.
	always_comb begin
		age_live = ({1'b0, timeout_q} >= age_q);
		age_n    = age_live ? (age_q + AGE_BITS'(tick_ms)) : age_q;
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					unique case (req_type_t'(req_type))
						REQ_TICK, REQ_ZEDGE: state_d = ST_ADD;
						REQ_RISE, REQ_FALL:  state_d = seen_rise_q ? ST_SPAN : ST_DONE;
						default:             state_d = ST_DONE;
					endcase
				end
			end
			ST_ADD: begin
				if (last_dig) begin
					state_d = ST_DONE;
				end
			end
			ST_SPAN: begin
				if (last_dig) begin
					state_d = ST_WRAP;
				end
			end
			ST_WRAP: begin
				if (last_dig) begin
					state_d = (k_sum[DIGIT_BITS] && nz_n) ? ST_DIV_LOAD : ST_DONE;
				end
			end
			ST_DIV_LOAD: state_d = ST_DIV;
			ST_DIV: begin
				if (last_div) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Held item.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q    <= req_type_t'(req_type);
			sample_q <= qei_count;
			down_q   <= qei_down;
			cap_q    <= capture_value;
		end
	end

	// Tracking state and digit sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q     <= '0;
			zoff_q      <= '0;
			pos_q       <= '0;
			last_q      <= '0;
			turn_q      <= '0;
			zpos_q      <= '0;
			last_rise_q <= '0;
			period_q    <= '0;
			high_q      <= '0;
			age_q       <= AGE_RESET;
			seen_rise_q <= 1'b0;
			pwm_ok_q    <= 1'b0;
			in_range_q  <= 1'b0;
			angle_q     <= '0;
			dig_q       <= '0;
			dbor_q      <= 1'b0;
			acy_q       <= 1'b0;
			pcy_q       <= 1'b0;
			tcy_q       <= 1'b0;
			scy_q       <= 1'b0;
			wcy_q       <= 1'b0;
			kcy_q       <= 1'b0;
			sign_q      <= 1'b0;
			wrap_q      <= 1'b0;
			nz_q        <= 1'b0;
			tmp_q       <= '0;
			rem_q       <= '0;
			quot_q      <= '0;
			div_cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						// Chains start on the lowest digit with their carry-in.
						dig_q  <= '0;
						dbor_q <= 1'b0;
						acy_q  <= invert_q;
						pcy_q  <= 1'b1;
						tcy_q  <= 1'b0;
						scy_q  <= 1'b1;
						sign_q <= 1'b0;
						unique case (req_type_t'(req_type))
							REQ_TICK: begin
								age_q <= age_n;
								if ({1'b0, timeout_q} < age_n) begin
									pwm_ok_q <= 1'b0;
								end
							end
							REQ_RISE: begin
								if (!seen_rise_q) begin
									last_rise_q <= capture_value;
									seen_rise_q <= 1'b1;
								end
							end
							REQ_SET_ZERO: begin
								zoff_q <= accum_q;
								pos_q  <= '0;
								turn_q <= '0;
								zpos_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_ADD: begin
					dbor_q <= d_sum[DIGIT_BITS];
					acy_q  <= a_sum[DIGIT_BITS];
					pcy_q  <= p_sum[DIGIT_BITS];
					tcy_q  <= t_sum[DIGIT_BITS];
					dig_q  <= dig_q + DIG_IDX_BITS'(1);
					if (dig_q == DIG_IDX_BITS'(CNT_DIGITS - 1)) begin
						sign_q <= d_sum[DIGIT_BITS-1];
					end
					if (req_q == REQ_TICK) begin
						accum_q[dsel +: DIGIT_BITS] <= a_sum[DIGIT_BITS-1:0];
						pos_q[dsel +: DIGIT_BITS]   <= p_sum[DIGIT_BITS-1:0];
						if (cnt_lo) begin
							last_q[csel +: DIGIT_BITS] <= s_dig;
						end
					end else begin
						zpos_q[dsel +: DIGIT_BITS] <= p_sum[DIGIT_BITS-1:0];
						turn_q[dsel +: DIGIT_BITS] <= t_sum[DIGIT_BITS-1:0];
					end
				end
				ST_SPAN: begin
					tmp_q[dsel +: DIGIT_BITS] <= x_sum[DIGIT_BITS-1:0];
					scy_q <= x_sum[DIGIT_BITS];
					dig_q <= dig_q + DIG_IDX_BITS'(1);
					if (last_dig) begin
						// A final borrow means the timer wrapped: add load plus one.
						wrap_q <= !x_sum[DIGIT_BITS];
						wcy_q  <= !x_sum[DIGIT_BITS];
						kcy_q  <= 1'b0;
						nz_q   <= 1'b0;
						dig_q  <= '0;
						if (is_rise) begin
							last_rise_q <= cap_q;
						end
					end
				end
				ST_WRAP: begin
					if (is_rise) begin
						period_q[dsel +: DIGIT_BITS] <= r_sum[DIGIT_BITS-1:0];
					end else begin
						high_q[dsel +: DIGIT_BITS] <= r_sum[DIGIT_BITS-1:0];
					end
					wcy_q <= r_sum[DIGIT_BITS];
					kcy_q <= k_sum[DIGIT_BITS];
					nz_q  <= nz_n;
					dig_q <= dig_q + DIG_IDX_BITS'(1);
					if (last_dig) begin
						in_range_q <= k_sum[DIGIT_BITS] && nz_n;
						dig_q      <= '0;
						// A falling edge inside the period refreshes the reading.
						if (!is_rise && k_sum[DIGIT_BITS] && nz_n) begin
							age_q    <= '0;
							pwm_ok_q <= 1'b1;
						end
					end
				end
				ST_DIV_LOAD: begin
					rem_q     <= high_q;
					quot_q    <= '0;
					div_cnt_q <= '0;
				end
				ST_DIV: begin
					rem_q     <= ge ? dv[WORD_BITS-1:0] : r2[WORD_BITS-1:0];
					quot_q    <= quot_n;
					div_cnt_q <= div_cnt_q + DIV_CNT_BITS'(1);
					if (last_div) begin
						angle_q <= angle_n;
					end
				end
				ST_DONE: ;
				default: ;
			endcase
		end
	end

	// Result register: loads when the previous result has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pos_q    <= pos_q;
			out_turn_q   <= turn_q;
			out_zpos_q   <= zpos_q;
			out_avalid_q <= pwm_ok_q && in_range_q;
			out_angle_q  <= (pwm_ok_q && in_range_q) ? angle_q : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign position      = signed'(out_pos_q);
	assign z_turns       = signed'(out_turn_q);
	assign position_at_z = signed'(out_zpos_q);
	assign angle_valid   = out_avalid_q;
	assign pwm_angle     = out_angle_q;

endmodule
